[design/wus_pkg.sv]
// package: types and codes for the weighted urn sampler
`timescale 1ns / 1ps
package wus_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  localparam logic [63:0] EMPTY_MARK = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] elem_weight;
    logic [63:0] elem_value;
    logic [63:0] pick_index;
  } in_item_t;

  typedef struct packed {
    logic [63:0] chosen_value;
    logic [2:0]  status;
    logic [63:0] urn_total;
    logic [8:0]  element_count;
  } out_item_t;

endpackage

[design/weighted_urn_sampler.sv]
// weighted urn sampler: sum tree in memory walked under a sequencer; most sums go through one shared adder
// one transaction at a time; each tree level costs one memory read and one write, compare or add
// the node sum memory and leaf value memory have one port each
// after reset all 2^(L+1) entries of the node sum memory are cleared, one entry a cycle, in_stall high
// out register parts the sides; in_stall is low only in idle, a result waits while the last stalls
`timescale 1ns / 1ps
module weighted_urn_sampler #(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wus_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wus_pkg::out_item_t out_data
);

  localparam int LV    = (CAPACITY <= 2) ? 1 : $clog2(CAPACITY);
  localparam int NODES = 2 ** (LV + 1);
  localparam int NW    = LV + 1;
  localparam int LEAVES = 2 ** LV;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int BW    = (LV <= 1) ? 1 : $clog2(LV);

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_DEC    = 5'd2;
  // descend for sample / locate
  localparam logic [4:0] S_DRD    = 5'd3;
  localparam logic [4:0] S_DCMP   = 5'd4;
  // read a leaf weight
  localparam logic [4:0] S_LRD    = 5'd5;
  localparam logic [4:0] S_LGET   = 5'd6;
  // weight before last leaf
  localparam logic [4:0] S_BRD    = 5'd7;
  localparam logic [4:0] S_BACC   = 5'd8;
  // set leaf weight: write the new weight at the leaf, then per node read, write node+d, go up
  localparam logic [4:0] S_URD    = 5'd9;
  localparam logic [4:0] S_UWR    = 5'd10;
  localparam logic [4:0] S_VRD    = 5'd11;
  localparam logic [4:0] S_VGET   = 5'd12;
  localparam logic [4:0] S_RDEC   = 5'd13;
  localparam logic [4:0] S_OUT    = 5'd14;
  localparam logic [4:0] S_SAMPV  = 5'd15;
  localparam logic [4:0] S_SAMPG  = 5'd16;
  localparam logic [4:0] S_SWV    = 5'd17;
  localparam logic [4:0] S_SWG    = 5'd18;

  // follow-up after an update walk
  localparam logic [1:0] AF_INS  = 2'd0;
  localparam logic [1:0] AF_REM0 = 2'd1;
  localparam logic [1:0] AF_SWAP = 2'd2;

  logic [63:0] node_mem [NODES];
  logic [63:0] leaf_mem [LEAVES];

  logic [4:0]  state_r, state_nxt;
  logic [NW-1:0] node_r, node_nxt;
  logic [NW-1:0] addr;
  logic        nwe;
  logic [63:0] nwdata;
  logic [63:0] nrd_r;
  logic        lwe;
  logic [LV-1:0] laddr;
  logic [63:0] lrd_r;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [63:0] total_r, total_nxt;
  wus_pkg::in_item_t req_r, req_nxt;
  logic [63:0] idx_r, idx_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] dw_r, dw_nxt;       // target weight, then delta
  logic [63:0] lw_r, lw_nxt;
  logic [63:0] lval_r, lval_nxt;
  logic [LV-1:0] pos_r, pos_nxt;
  logic [LV-1:0] lp_r, lp_nxt;
  logic [LV:0] step_r, step_nxt;
  logic [1:0]  after_r, after_nxt;
  logic [63:0] chosen_r, chosen_nxt;
  logic [2:0]  stat_r, stat_nxt;
  logic        ov_r, ov_nxt;
  wus_pkg::out_item_t od_r, od_nxt;
  logic [BW-1:0] bsel;

  // shared adder
  logic [63:0] add_a, add_b, add_y;
  assign add_y = add_a + add_b;

  function automatic logic [LV-1:0] brev(input logic [CW-1:0] k);
    logic [LV-1:0] r;
    for (int i = 0; i < LV; i++) r[LV-1-i] = k[i];
    return r;
  endfunction

  function automatic logic [NW-1:0] leaf_node(input logic [LV-1:0] p);
    return NW'(LEAVES - 1) + NW'(p);
  endfunction

  always_ff @(posedge clk) begin
    if (nwe) node_mem[addr] <= nwdata;
    nrd_r <= node_mem[addr];
    if (lwe) leaf_mem[laddr] <= req_r.elem_value;
    lrd_r <= leaf_mem[laddr];
  end

  logic [CW-1:0] cm1;
  assign cm1 = cnt_r - CW'(1);

  // path bit of the last leaf at the current level, msb first
  assign bsel = BW'(LV - 1) - BW'(step_r);

  always_comb begin
    state_nxt = state_r; node_nxt = node_r; cnt_nxt = cnt_r; total_nxt = total_r;
    req_nxt = req_r; idx_nxt = idx_r; acc_nxt = acc_r; dw_nxt = dw_r; lw_nxt = lw_r;
    lval_nxt = lval_r; pos_nxt = pos_r; lp_nxt = lp_r; step_nxt = step_r;
    after_nxt = after_r; chosen_nxt = chosen_r; stat_nxt = stat_r; ov_nxt = ov_r;
    od_nxt = od_r;
    addr = node_r; nwe = 1'b0; nwdata = 64'd0; lwe = 1'b0; laddr = pos_r;
    add_a = 64'd0; add_b = 64'd0;
    in_stall = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        nwe = 1'b1;
        node_nxt = node_r + NW'(1);
        if (node_r == NW'(NODES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          req_nxt = in_data;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        chosen_nxt = 64'd0; stat_nxt = wus_pkg::ST_OK; state_nxt = S_OUT;
        idx_nxt = req_r.pick_index; node_nxt = '0; step_nxt = '0; acc_nxt = 64'd0;
        if (req_r.cmd == wus_pkg::CMD_INSERT) begin
          if (cnt_r >= CW'(CAPACITY)) stat_nxt = wus_pkg::ST_FULL;
          else if (req_r.elem_weight > ~total_r) stat_nxt = wus_pkg::ST_OVERFLOW;
          else begin
            pos_nxt = brev(cnt_r); dw_nxt = req_r.elem_weight;
            node_nxt = leaf_node(brev(cnt_r)); after_nxt = AF_INS;
            state_nxt = S_URD;
          end
        end else if (req_r.cmd == wus_pkg::CMD_SAMPLE ||
                     req_r.cmd == wus_pkg::CMD_REMOVE) begin
          if (cnt_r == '0) begin
            stat_nxt = wus_pkg::ST_EMPTY; chosen_nxt = wus_pkg::EMPTY_MARK;
          end else if (req_r.pick_index >= total_r) stat_nxt = wus_pkg::ST_RANGE;
          else if (req_r.cmd == wus_pkg::CMD_SAMPLE) begin
            node_nxt = NW'(1); state_nxt = S_DRD; after_nxt = AF_INS;
          end else begin
            lp_nxt = brev(cm1); pos_nxt = brev(cm1);
            node_nxt = leaf_node(brev(cm1)); state_nxt = S_LRD;
          end
        end
      end
      S_DRD: state_nxt = S_DCMP;   // node_r is a left child, its sum is read into nrd_r
      S_DCMP: begin
        if (idx_r < nrd_r) node_nxt = node_r;
        else begin
          add_a = idx_r; add_b = ~nrd_r + 64'd0;
          idx_nxt = add_y + 64'd1;
          node_nxt = node_r + NW'(1);
        end
        step_nxt = step_r + (LV + 1)'(1);
        if (step_r == (LV + 1)'(LV - 1)) begin
          pos_nxt = LV'((idx_r < nrd_r ? node_r : node_r + NW'(1)) - NW'(LEAVES - 1));
          state_nxt = (after_r == AF_SWAP) ? S_SWV : S_SAMPV;
        end else begin
          node_nxt = ((idx_r < nrd_r) ? node_r : node_r + NW'(1)) * NW'(2) + NW'(1);
          state_nxt = S_DRD;
        end
      end
      S_SAMPV: begin laddr = pos_r; state_nxt = S_SAMPG; end
      S_SAMPG: begin chosen_nxt = lrd_r; state_nxt = S_OUT; end
      S_LRD: state_nxt = S_LGET;
      S_LGET: begin
        lw_nxt = nrd_r; node_nxt = NW'(1); step_nxt = '0; acc_nxt = 64'd0;
        state_nxt = S_VRD;
      end
      S_VRD: begin laddr = lp_r; state_nxt = S_VGET; end
      S_VGET: begin lval_nxt = lrd_r; state_nxt = S_BRD; end
      S_BRD: state_nxt = S_BACC;
      S_BACC: begin
        step_nxt = step_r + (LV + 1)'(1);
        if (lp_r[bsel]) begin
          add_a = acc_r; add_b = nrd_r; acc_nxt = add_y;
          node_nxt = (node_r + NW'(1)) * NW'(2) + NW'(1);
        end else node_nxt = node_r * NW'(2) + NW'(1);
        if (step_r == (LV + 1)'(LV - 1)) begin
          // acc holds weight before last leaf; clear last leaf weight
          dw_nxt = 64'd0; pos_nxt = lp_r; node_nxt = leaf_node(lp_r);
          after_nxt = AF_REM0; state_nxt = S_URD;
        end else state_nxt = S_BRD;
      end
      S_URD: state_nxt = S_UWR;
      S_UWR: begin
        if (node_r == leaf_node(pos_r)) begin
          add_a = dw_r; add_b = ~nrd_r; dw_nxt = add_y + 64'd1;
          nwe = 1'b1; nwdata = dw_r;
        end else begin
          add_a = nrd_r; add_b = dw_r; nwe = 1'b1; nwdata = add_y;
        end
        if (node_r == '0) begin
          add_a = nrd_r; add_b = (node_r == leaf_node(pos_r)) ? dw_r - nrd_r : dw_r;
          total_nxt = add_y;
          nwdata = add_y;
          unique case (after_r)
            AF_INS: begin
              lwe = 1'b1; laddr = pos_r; cnt_nxt = cnt_r + CW'(1); state_nxt = S_OUT;
            end
            AF_REM0: begin
              cnt_nxt = cm1; state_nxt = S_RDEC;
            end
            default: begin
              lwe = 1'b1; laddr = pos_r; state_nxt = S_OUT;
            end
          endcase
        end else begin
          node_nxt = (node_r - NW'(1)) >> 1;
          state_nxt = S_URD;
        end
      end
      S_RDEC: begin
        chosen_nxt = lval_r; state_nxt = S_OUT;
        req_nxt.elem_value = lval_r;
        node_nxt = NW'(1); step_nxt = '0; after_nxt = AF_SWAP; dw_nxt = lw_r;
        if (cnt_r == '0) state_nxt = S_OUT;
        else if (idx_r < acc_r) state_nxt = S_DRD;
        else if (idx_r - acc_r < lw_r) state_nxt = S_OUT;
        else begin
          add_a = idx_r; add_b = ~lw_r; idx_nxt = add_y + 64'd1; state_nxt = S_DRD;
        end
      end
      S_SWV: begin laddr = pos_r; state_nxt = S_SWG; end
      S_SWG: begin
        chosen_nxt = lrd_r; dw_nxt = lw_r; node_nxt = leaf_node(pos_r);
        state_nxt = S_URD;
      end
      S_OUT: begin
        // hold until the out register is free
        if (!ov_r || !out_stall) begin
          od_nxt.chosen_value = chosen_r; od_nxt.status = stat_r;
          od_nxt.urn_total = total_r; od_nxt.element_count = 9'(cnt_r);
          ov_nxt = 1'b1; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    if (ov_r && !out_stall) ov_nxt = (state_r == S_OUT);
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; node_r <= '0; cnt_r <= '0; total_r <= 64'd0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; node_r <= node_nxt; cnt_r <= cnt_nxt;
      total_r <= total_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; idx_r <= idx_nxt; acc_r <= acc_nxt; dw_r <= dw_nxt;
    lw_r <= lw_nxt; lval_r <= lval_nxt; pos_r <= pos_nxt; lp_r <= lp_nxt;
    step_r <= step_nxt; after_r <= after_nxt; chosen_r <= chosen_nxt;
    stat_r <= stat_nxt; od_r <= od_nxt;
  end

endmodule
